@@ src/cps_pkg.sv @@
// Shared types, codes and fixed-point constants of the clock PI servo.
package cps_pkg;

  localparam int FREQ_FRAC_BITS = 16;
  localparam int GAIN_FRAC_BITS = 24;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int TERM_SHIFT = GAIN_FRAC_BITS + WEIGHT_FRAC_BITS - FREQ_FRAC_BITS;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 47;

  // Longest sample spacing that still waits: 1000 s less the 0.1% margin.
  localparam logic [63:0] WAIT_DIFF_MAX = 64'd999000999000;
  // Wait while spacing * 1001 * ki < 0.016 s * 1e12 in gain format.
  localparam logic [127:0] WAIT_LIMIT = 128'(64'd16000000000) << GAIN_FRAC_BITS;
  localparam logic [63:0] ONE_E9_FIXED = 64'd1000000000 << FREQ_FRAC_BITS;
  localparam logic [127:0] TERM_SAT = 128'd1 << 60;
  localparam logic [63:0] DRIFT_SAT = 64'd1 << 61;
  localparam logic [63:0] DRIFT_Q_CAP = 64'd1 << 62;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PROP_GAIN       = 3'd0,
    REG_INTEG_GAIN      = 3'd1,
    REG_MAX_FREQ_PPB    = 3'd2,
    REG_STEP_LIMIT_NS   = 3'd3,
    REG_FIRST_STEP_NS   = 3'd4,
    REG_RAMP_LENGTH_NS  = 3'd5,
    REG_START_DRIFT     = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_UNLOCKED = 2'd0,
    ST_JUMP     = 2'd1,
    ST_LOCKED   = 2'd2
  } lock_state_t;

  typedef enum logic [0:0] {
    ARITH_MUL = 1'b0,
    ARITH_DIV = 1'b1
  } arith_op_t;

  // For a multiply a[63:0] * b; for a divide a / b limited to cap.
  typedef struct packed {
    logic         start;
    arith_op_t    op;
    logic [127:0] a;
    logic [63:0]  b;
    logic [63:0]  cap;
  } arith_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] res;
  } arith_rsp_t;

endpackage

@@ src/cps_if.sv @@
// Handshake channels of the clock PI servo: samples, results and configuration writes.
interface cps_sample_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [47:0] offset_ns;
  logic [63:0]        local_time_ns;
  logic [16:0]        sample_weight;
  logic               no_update_yet;

  modport source(output valid, cmd, offset_ns, local_time_ns, sample_weight, no_update_yet,
                 input ready);
  modport sink(input valid, cmd, offset_ns, local_time_ns, sample_weight, no_update_yet,
               output ready);
endinterface

interface cps_result_if;
  logic               valid;
  logic               ready;
  logic signed [46:0] freq_ppb;
  logic [1:0]         lock_state;

  modport source(output valid, freq_ppb, lock_state, input ready);
  modport sink(input valid, freq_ppb, lock_state, output ready);
endinterface

interface cps_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [46:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ src/cps_arith.sv @@
// Shared bit-serial unit: 64x64 multiply and saturating 128/64 divide, one bit per cycle.
module cps_arith (
  input  logic               clk,
  input  logic               rst,
  input  cps_pkg::arith_req_t req,
  output cps_pkg::arith_rsp_t rsp
);
  import cps_pkg::*;

  logic         busy;
  logic         done_r;
  logic [5:0]   cnt;
  arith_op_t    op_r;
  logic [127:0] acc;
  logic [127:0] ma;
  logic [63:0]  mb;
  logic [63:0]  rem;
  logic [63:0]  nlo;
  logic [63:0]  dv;
  logic [63:0]  q;
  logic [63:0]  cap_r;
  logic [64:0]  r2;
  logic [64:0]  r2_sub;
  logic         take;
  logic [63:0]  rem_next;
  logic         div_ovf;

  assign r2       = {rem, nlo[63]};
  assign r2_sub   = r2 - {1'b0, dv};
  assign take     = (r2 >= {1'b0, dv});
  assign rem_next = take ? r2_sub[63:0] : r2[63:0];
  // A quotient that would not fit in 64 bits goes straight to the cap.
  assign div_ovf  = (req.a[127:64] >= req.b);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
      cnt    <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt <= '0;
        if (req.op == ARITH_DIV && div_ovf) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      acc   <= '0;
      ma    <= {64'd0, req.a[63:0]};
      mb    <= req.b;
      rem   <= req.a[127:64];
      nlo   <= req.a[63:0];
      dv    <= req.b;
      cap_r <= req.cap;
      q     <= (req.op == ARITH_DIV && div_ovf) ? req.cap : 64'd0;
    end else if (busy) begin
      unique case (op_r)
        ARITH_MUL: begin
          if (mb[0]) begin
            acc <= acc + ma;
          end
          ma <= ma << 1;
          mb <= mb >> 1;
        end
        ARITH_DIV: begin
          rem <= rem_next;
          q   <= {q[62:0], take};
          nlo <= nlo << 1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rsp.done = done_r;
    unique case (op_r)
      ARITH_MUL: rsp.res = acc;
      ARITH_DIV: rsp.res = {64'd0, (q < cap_r) ? q : cap_r};
      default:   rsp.res = acc;
    endcase
  end

endmodule

@@ src/clock_pi_servo_unit.sv @@
// Top level of the clock PI servo: configuration, sequencer and result register.
//
//   channel  direction  transaction
//   cfg      in         one register write (index, data)
//   sample   in         one offset sample or restart command
//   result   out        frequency adjustment and servo state
//
// A restart, a first sample, an unlock or a sample out of order goes straight to a
// result; a sample while waiting for lock, the lock sample, a PI update and a PI
// update during the gain ramp use the shared unit. Each multiply or divide there runs
// one bit per cycle; a divide whose quotient overflows goes straight to the cap.
// Reset is synchronous and needs no clearing pass. A sample is taken only while the
// sequencer is idle; a result left waiting on the result channel holds the sequencer
// at its next result.
module clock_pi_servo_unit (
  input  logic         clk,
  input  logic         rst,
  cps_cfg_if.sink      cfg,
  cps_sample_if.sink   sample,
  cps_result_if.source result
);
  import cps_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DECIDE = 13'b0000000000010,
    S_WMUL   = 13'b0000000000100,
    S_DMUL   = 13'b0000000001000,
    S_DDIV   = 13'b0000000010000,
    S_RMUL   = 13'b0000000100000,
    S_RDIV   = 13'b0000001000000,
    S_TMULW  = 13'b0000010000000,
    S_TMULO  = 13'b0000100000000,
    S_PFIN   = 13'b0001000000000,
    S_DONE   = 13'b0010000000000
  } seq_state_t;

  // Configuration registers. The start drift only takes effect through reset,
  // where it always holds its reset value of zero, so it is not stored.
  logic [39:0] prop_gain;
  logic [39:0] integ_gain;
  logic [29:0] max_freq_ppb;
  logic [31:0] step_limit_ns;
  logic [31:0] first_step_limit_ns;
  logic [41:0] ramp_length_ns;

  // Servo state.
  seq_state_t         state;
  logic [1:0]         phase;
  logic signed [47:0] first_offset;
  logic [63:0]        first_time;
  logic signed [63:0] drift;
  logic signed [63:0] last_output;
  logic               ramp_on;
  logic [63:0]        ramp_start_time;
  logic [41:0]        ramp_prop_gain;
  logic [41:0]        ramp_integ_gain;

  // Working registers of one transaction.
  logic               cmd_r;
  logic signed [47:0] off_r;
  logic [63:0]        t_r;
  logic [16:0]        w_r;
  logic               fu_r;
  logic [63:0]        span;
  logic [127:0]       prod;
  logic [41:0]        ekp;
  logic [41:0]        eki;
  logic signed [61:0] kt;
  logic signed [61:0] it;
  logic               sel;
  logic               issued;
  logic signed [63:0] ppb_r;
  lock_state_t        st_r;

  // Result register.
  logic               out_valid;
  logic signed [46:0] out_freq;
  lock_state_t        out_st;

  arith_req_t req;
  arith_rsp_t rsp;

  cps_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Derived values.
  logic [47:0]        aoff;
  logic signed [63:0] lim;
  logic signed [63:0] num;
  logic [63:0]        mag_num;
  logic signed [48:0] doff;
  logic [48:0]        mag_doff;
  logic [63:0]        d1001;
  logic [63:0]        el;
  logic [41:0]        st_g;
  logic [41:0]        k_g;
  logic               g_ge;
  logic [41:0]        gdiff;
  logic [41:0]        gain_sel;
  logic               step_hit;
  logic               first_hit;
  logic               wait_more;
  logic [63:0]        dstep;
  logic signed [63:0] dsum;
  logic signed [63:0] dsat;
  logic [41:0]        ramp_e;
  logic [127:0]       term_sh;
  logic [60:0]        term_mag;
  logic signed [61:0] term_val;
  logic signed [63:0] pi_sum;
  logic signed [63:0] drift_it;
  logic signed [63:0] drift_it_sat;

  always_comb begin
    aoff      = off_r[47] ? (~off_r + 48'd1) : off_r;
    lim       = 64'(max_freq_ppb) << FREQ_FRAC_BITS;
    num       = ONE_E9_FIXED - drift;
    mag_num   = num[63] ? (~num + 64'd1) : num;
    doff      = {off_r[47], off_r} - {first_offset[47], first_offset};
    mag_doff  = doff[48] ? (~doff + 49'd1) : doff;
    d1001     = (span << 10) - (span << 4) - (span << 3) + span;
    el        = t_r - ramp_start_time;
    st_g      = sel ? ramp_integ_gain : ramp_prop_gain;
    k_g       = sel ? {2'b00, integ_gain} : {2'b00, prop_gain};
    g_ge      = (st_g >= k_g);
    gdiff     = g_ge ? (st_g - k_g) : (k_g - st_g);
    gain_sel  = sel ? eki : ekp;
    step_hit  = (step_limit_ns != 32'd0) && ({16'd0, step_limit_ns} < aoff);
    first_hit = fu_r && (first_step_limit_ns != 32'd0) &&
                ({16'd0, first_step_limit_ns} < aoff);
    wait_more = (span <= WAIT_DIFF_MAX) &&
                ((integ_gain == 40'd0) || (rsp.res < WAIT_LIMIT));

    // Drift estimate: the quotient carries the sign of num * doff.
    dstep = (num[63] != doff[48]) ? (~rsp.res[63:0] + 64'd1) : rsp.res[63:0];
    dsum  = drift + dstep;
    priority if (dsum > lim) begin
      dsat = lim;
    end else if (dsum < -lim) begin
      dsat = -lim;
    end else begin
      dsat = dsum;
    end

    ramp_e = g_ge ? (st_g - rsp.res[41:0]) : (st_g + rsp.res[41:0]);

    term_sh  = rsp.res >> TERM_SHIFT;
    term_mag = (term_sh > TERM_SAT) ? TERM_SAT[60:0] : term_sh[60:0];
    term_val = off_r[47] ? (~{1'b0, term_mag} + 62'd1) : {1'b0, term_mag};

    pi_sum   = {{2{kt[61]}}, kt} + drift + {{2{it[61]}}, it};
    drift_it = drift + {{2{it[61]}}, it};
    priority if (drift_it > $signed(DRIFT_SAT)) begin
      drift_it_sat = DRIFT_SAT;
    end else if (drift_it < -$signed(DRIFT_SAT)) begin
      drift_it_sat = -DRIFT_SAT;
    end else begin
      drift_it_sat = drift_it;
    end
  end

  // Operands for the shared unit, issued once on entry to each step.
  always_comb begin
    req       = '0;
    req.op    = ARITH_MUL;
    unique case (state)
      S_WMUL: begin
        req.start = !issued;
        req.a     = {64'd0, d1001};
        req.b     = {24'd0, integ_gain};
      end
      S_DMUL: begin
        req.start = !issued;
        req.a     = {64'd0, mag_num};
        req.b     = {15'd0, mag_doff};
      end
      S_DDIV: begin
        req.start = !issued;
        req.op    = ARITH_DIV;
        req.a     = prod;
        req.b     = span;
        req.cap   = DRIFT_Q_CAP;
      end
      S_RMUL: begin
        req.start = !issued;
        req.a     = {86'd0, gdiff};
        req.b     = span;
      end
      S_RDIV: begin
        req.start = !issued;
        req.op    = ARITH_DIV;
        req.a     = prod;
        req.b     = {22'd0, ramp_length_ns};
        req.cap   = {22'd0, gdiff};
      end
      S_TMULW: begin
        req.start = !issued;
        req.a     = {86'd0, gain_sel};
        req.b     = {47'd0, w_r};
      end
      S_TMULO: begin
        req.start = !issued;
        req.a     = {64'd0, prod[63:0]};
        req.b     = {16'd0, aoff};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain           <= '0;
      integ_gain          <= '0;
      max_freq_ppb        <= 30'd900000000;
      step_limit_ns       <= '0;
      first_step_limit_ns <= 32'd20000;
      ramp_length_ns      <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_PROP_GAIN:      prop_gain           <= cfg.data[39:0];
        REG_INTEG_GAIN:     integ_gain          <= cfg.data[39:0];
        REG_MAX_FREQ_PPB:   max_freq_ppb        <= cfg.data[29:0];
        REG_STEP_LIMIT_NS:  step_limit_ns       <= cfg.data[31:0];
        REG_FIRST_STEP_NS:  first_step_limit_ns <= cfg.data[31:0];
        REG_RAMP_LENGTH_NS: ramp_length_ns      <= cfg.data[41:0];
        REG_START_DRIFT: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      issued          <= 1'b0;
      sel             <= 1'b0;
      phase           <= 2'd0;
      first_offset    <= '0;
      first_time      <= '0;
      drift           <= '0;
      last_output     <= '0;
      ramp_on         <= 1'b0;
      ramp_start_time <= '0;
      ramp_prop_gain  <= '0;
      ramp_integ_gain <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (rsp.done) begin
        issued <= 1'b0;
      end else if (req.start) begin
        issued <= 1'b1;
      end
      if (state == S_DONE && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            cmd_r <= sample.cmd;
            off_r <= sample.offset_ns;
            t_r   <= sample.local_time_ns;
            w_r   <= sample.sample_weight;
            fu_r  <= sample.no_update_yet;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          ppb_r <= last_output;
          st_r  <= ST_UNLOCKED;
          sel   <= 1'b0;
          ekp   <= {2'b00, prop_gain};
          eki   <= {2'b00, integ_gain};
          if (cmd_r) begin
            phase   <= 2'd0;
            ramp_on <= 1'b0;
            state   <= S_DONE;
          end else if (phase == 2'd1) begin
            if (first_time >= t_r) begin
              phase <= 2'd0;
              state <= S_DONE;
            end else begin
              span  <= t_r - first_time;
              state <= S_WMUL;
            end
          end else if (phase == 2'd2) begin
            if (step_hit) begin
              phase   <= 2'd0;
              ramp_on <= 1'b0;
              state   <= S_DONE;
            end else if (ramp_on) begin
              if (ramp_length_ns == 42'd0 || el >= {22'd0, ramp_length_ns}) begin
                ramp_on <= 1'b0;
                state   <= S_TMULW;
              end else begin
                span  <= el;
                state <= S_RMUL;
              end
            end else begin
              state <= S_TMULW;
            end
          end else begin
            first_offset <= off_r;
            first_time   <= t_r;
            phase        <= 2'd1;
            state        <= S_DONE;
          end
        end
        S_WMUL: begin
          if (rsp.done) begin
            state <= wait_more ? S_DONE : S_DMUL;
          end
        end
        S_DMUL: begin
          if (rsp.done) begin
            prod  <= rsp.res;
            state <= S_DDIV;
          end
        end
        S_DDIV: begin
          if (rsp.done) begin
            drift <= dsat;
            ppb_r <= dsat;
            st_r  <= (first_hit || step_hit) ? ST_JUMP : ST_LOCKED;
            phase <= 2'd2;
            if (ramp_length_ns != 42'd0) begin
              ramp_on         <= 1'b1;
              ramp_start_time <= t_r;
              ramp_prop_gain  <= {2'b00, prop_gain} + {1'b0, prop_gain, 1'b0};
              ramp_integ_gain <= {2'b00, integ_gain} + {1'b0, integ_gain, 1'b0};
            end
            state <= S_DONE;
          end
        end
        S_RMUL: begin
          if (rsp.done) begin
            prod  <= rsp.res;
            state <= S_RDIV;
          end
        end
        S_RDIV: begin
          if (rsp.done) begin
            if (sel) begin
              eki   <= ramp_e;
              sel   <= 1'b0;
              state <= S_TMULW;
            end else begin
              ekp   <= ramp_e;
              sel   <= 1'b1;
              state <= S_RMUL;
            end
          end
        end
        S_TMULW: begin
          if (rsp.done) begin
            prod  <= rsp.res;
            state <= S_TMULO;
          end
        end
        S_TMULO: begin
          if (rsp.done) begin
            if (sel) begin
              it    <= term_val;
              sel   <= 1'b0;
              state <= S_PFIN;
            end else begin
              kt    <= term_val;
              sel   <= 1'b1;
              state <= S_TMULW;
            end
          end
        end
        S_PFIN: begin
          // The integral is held while the output sits at the limit.
          priority if (pi_sum < -lim) begin
            ppb_r <= -lim;
          end else if (pi_sum > lim) begin
            ppb_r <= lim;
          end else begin
            ppb_r <= pi_sum;
            drift <= drift_it_sat;
          end
          st_r  <= ST_LOCKED;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_freq    <= ppb_r[46:0];
            out_st      <= st_r;
            last_output <= ppb_r;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cfg.ready         = 1'b1;
  assign sample.ready      = (state == S_IDLE);
  assign result.valid      = out_valid;
  assign result.freq_ppb   = out_freq;
  assign result.lock_state = out_st;

endmodule
